/* sv/pqts_pkg.sv */
`default_nettype none
package pqts_pkg;

    localparam int MAX_TASKS_DEF  = 128;
    localparam int NUM_LEVELS_DEF = 4;
    localparam int QUEUE_DEPTH    = 4;

    // event codes on s_tuser
    localparam logic [2:0] MODE_TICK   = 3'd0;
    localparam logic [2:0] MODE_CREATE = 3'd1;
    localparam logic [2:0] MODE_SETP   = 3'd2;
    localparam logic [2:0] MODE_BLOCK  = 3'd3;
    localparam logic [2:0] MODE_READY  = 3'd4;
    localparam logic [2:0] MODE_KILL   = 3'd5;

    // task states
    localparam logic [1:0] TS_READY      = 2'd0;
    localparam logic [1:0] TS_RUNNING    = 2'd1;
    localparam logic [1:0] TS_BLOCKED    = 2'd2;
    localparam logic [1:0] TS_TERMINATED = 2'd3;

    // result status
    localparam logic [1:0] STS_OK     = 2'd0;
    localparam logic [1:0] STS_REJECT = 2'd1;
    localparam logic [1:0] STS_NOIDLE = 2'd2;

    typedef enum logic [2:0] {
        OP_TICK,
        OP_CREATE,
        OP_SETP,
        OP_BLOCK,
        OP_READY,
        OP_KILL,
        OP_REJECT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [6:0] task_id;
        logic [1:0] prio;
    } entry_t;

    typedef struct packed {
        logic [2:0] quantum;
        logic [6:0] value;
        logic       switched;
        logic [6:0] running;
        logic [1:0] status;
    } result_t;

endpackage
`default_nettype wire

/* sv/pqts_front.sv */
`default_nettype none
module pqts_front import pqts_pkg::*; #(
    parameter int MAX_TASKS  = MAX_TASKS_DEF,
    parameter int NUM_LEVELS = NUM_LEVELS_DEF
) (
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,
    input  wire logic [2:0]  s_tuser,
    input  wire logic        q_full,
    output logic             q_push,
    output entry_t           q_entry
);

    logic [6:0] id;
    logic [1:0] prio;
    logic       id_ok;
    logic       prio_ok;

    assign id      = s_tdata[6:0];
    assign prio    = s_tdata[8:7];
    assign id_ok   = 32'(id) < MAX_TASKS;
    assign prio_ok = 32'(prio) < NUM_LEVELS;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_entry.task_id = id;
        q_entry.prio    = prio;
        unique case (s_tuser)
            MODE_TICK:   q_entry.op = OP_TICK;
            MODE_CREATE: q_entry.op = prio_ok ? OP_CREATE : OP_REJECT;
            MODE_SETP:   q_entry.op = (id_ok && id != 7'd0 && prio_ok) ? OP_SETP : OP_REJECT;
            MODE_BLOCK:  q_entry.op = (id_ok && id != 7'd0) ? OP_BLOCK : OP_REJECT;
            MODE_READY:  q_entry.op = (id_ok && id != 7'd0) ? OP_READY : OP_REJECT;
            MODE_KILL:   q_entry.op = (id_ok && id > 7'd2) ? OP_KILL : OP_REJECT;
            default:     q_entry.op = OP_REJECT;
        endcase
    end

endmodule
`default_nettype wire

/* sv/pqts_fifo.sv */
`default_nettype none
module pqts_fifo import pqts_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   push,
    input  wire entry_t push_data,
    output logic        full,
    input  wire logic   pop,
    output logic        not_empty,
    output entry_t      head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    entry_t          buf_reg [DEPTH];
    logic [PW-1:0]   wr_reg, rd_reg;
    logic [CW-1:0]   cnt_reg;
    logic            do_push, do_pop;

    assign full      = cnt_reg == CW'(DEPTH);
    assign not_empty = cnt_reg != '0;
    assign head      = buf_reg[rd_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            buf_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_push) begin
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + CW'(do_push) - CW'(do_pop);
        end
    end

endmodule
`default_nettype wire

/* sv/pqts_back.sv */
`default_nettype none
module pqts_back import pqts_pkg::*; #(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   q_valid,
    input  wire entry_t q_entry,
    output logic        q_pop,
    output logic        m_tvalid,
    input  wire logic   m_tready,
    output result_t     m_result
);

    localparam int IW  = $clog2(MAX_TASKS);
    localparam int LW  = $clog2(MAX_TASKS + 1);
    localparam int LVW = $clog2(MAX_TASKS + 1);
    localparam logic [LW-1:0] NIL = LW'(MAX_TASKS);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_EXEC  = 12'b0000_0000_0010,
        S_PF2   = 12'b0000_0000_0100,
        S_SCH0  = 12'b0000_0000_1000,
        S_SCH1  = 12'b0000_0001_0000,
        S_APP1  = 12'b0000_0010_0000,
        S_APP2  = 12'b0000_0100_0000,
        S_PICK  = 12'b0000_1000_0000,
        S_PICK2 = 12'b0001_0000_0000,
        S_CSCAN = 12'b0010_0000_0000,
        S_CUR   = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } fsm_t;

    // task table memories
    logic [1:0]    st_mem [MAX_TASKS];
    logic [1:0]    pr_mem [MAX_TASKS];
    logic [LW-1:0] nx_mem [MAX_TASKS];
    logic [LW-1:0] pv_mem [MAX_TASKS];

    logic [1:0]    st_rd_reg, pr_rd_reg;
    logic [LW-1:0] nx_rd_reg, pv_rd_reg;
    logic [IW-1:0] rd_addr;

    logic          st_we, pr_we, nx_we, pv_we;
    logic [IW-1:0] st_wa, pr_wa, nx_wa, pv_wa;
    logic [1:0]    st_wd, pr_wd;
    logic [LW-1:0] nx_wd, pv_wd;

    fsm_t                 state_reg, state_next;
    logic [MAX_TASKS-1:0] valid_reg, valid_next;
    logic [MAX_TASKS-1:0] inlist_reg, inlist_next;
    logic [LW-1:0]        head_reg, head_next, tail_reg, tail_next;
    logic [IW-1:0]        cur_reg, cur_next, cursor_reg, cursor_next;
    logic [LVW-1:0]       live_reg, live_next;
    logic [2:0]           rounds_reg, rounds_next;
    logic                 m_valid_reg, m_valid_next;
    result_t              out_reg, out_next;

    op_t                  op_reg, op_next;
    logic [IW-1:0]        tid_reg, tid_next, t_reg, t_next;
    logic [IW-1:0]        slot_reg, slot_next, scan_reg, scan_next;
    logic [1:0]           prio_reg, prio_next;
    logic [1:0]           status_reg, status_next;
    logic [6:0]           value_reg, value_next;
    logic                 switched_reg, switched_next;
    logic                 ret_create_reg, ret_create_next;

    logic                 unlink_en;
    logic [IW-1:0]        unlink_t;
    logic [IW-1:0]        q_tid, pick;
    logic                 alive;

    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] s);
        return (s == IW'(MAX_TASKS - 1)) ? '0 : s + 1'b1;
    endfunction

    assign q_tid    = IW'(q_entry.task_id);
    assign alive    = valid_reg[cur_reg];
    assign pick     = (head_reg == NIL) ? '0 : IW'(head_reg);
    assign m_tvalid = m_valid_reg;
    assign m_result = out_reg;

    always_comb begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        inlist_next     = inlist_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        cur_next        = cur_reg;
        cursor_next     = cursor_reg;
        live_next       = live_reg;
        rounds_next     = rounds_reg;
        m_valid_next    = m_valid_reg;
        out_next        = out_reg;
        op_next         = op_reg;
        tid_next        = tid_reg;
        t_next          = t_reg;
        slot_next       = slot_reg;
        scan_next       = scan_reg;
        prio_next       = prio_reg;
        status_next     = status_reg;
        value_next      = value_reg;
        switched_next   = switched_reg;
        ret_create_next = ret_create_reg;
        q_pop           = 1'b0;
        rd_addr         = cur_reg;
        unlink_en       = 1'b0;
        unlink_t        = tid_reg;
        st_we = 1'b0; st_wa = tid_reg; st_wd = TS_READY;
        pr_we = 1'b0; pr_wa = tid_reg; pr_wd = prio_reg;
        nx_we = 1'b0; nx_wa = tid_reg; nx_wd = NIL;
        pv_we = 1'b0; pv_wa = tid_reg; pv_wd = NIL;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                rd_addr = q_tid;
                if (q_valid) begin
                    q_pop         = 1'b1;
                    op_next       = q_entry.op;
                    tid_next      = q_tid;
                    prio_next     = q_entry.prio;
                    status_next   = STS_REJECT;
                    value_next    = '0;
                    switched_next = 1'b0;
                    state_next    = S_DONE;
                    case (q_entry.op)
                        OP_TICK: state_next = S_SCH0;
                        OP_CREATE: begin
                            if (live_reg != LVW'(MAX_TASKS)) begin
                                scan_next  = cursor_reg;
                                state_next = S_CSCAN;
                            end
                        end
                        OP_SETP: begin
                            if (valid_reg[q_tid]) begin
                                pr_we       = 1'b1;
                                pr_wa       = q_tid;
                                pr_wd       = q_entry.prio;
                                status_next = STS_OK;
                                value_next  = 7'(q_entry.prio);
                            end
                        end
                        OP_BLOCK, OP_READY, OP_KILL: begin
                            if (valid_reg[q_tid]) begin
                                state_next = S_EXEC;
                            end
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_EXEC: begin
                status_next = STS_OK;
                state_next  = S_DONE;
                case (op_reg)
                    OP_BLOCK: begin
                        value_next = 7'(TS_BLOCKED);
                        if (st_rd_reg != TS_BLOCKED) begin
                            st_we     = 1'b1;
                            st_wd     = TS_BLOCKED;
                            unlink_en = inlist_reg[tid_reg];
                            if (tid_reg == cur_reg) begin
                                rounds_next = '0;
                                state_next  = S_SCH0;
                            end
                        end
                    end
                    OP_READY: begin
                        value_next = 7'(TS_READY);
                        if (st_rd_reg != TS_READY) begin
                            st_we = 1'b1;
                            st_wd = TS_READY;
                            if (!inlist_reg[tid_reg]) begin
                                nx_we = 1'b1;
                                nx_wd = head_reg;
                                pv_we = 1'b1;
                                pv_wd = NIL;
                                inlist_next[tid_reg] = 1'b1;
                                state_next = S_PF2;
                            end
                        end
                    end
                    OP_KILL: begin
                        value_next = 7'(TS_TERMINATED);
                        st_we      = 1'b1;
                        st_wd      = TS_TERMINATED;
                        unlink_en  = inlist_reg[tid_reg];
                        valid_next[tid_reg] = 1'b0;
                        if (live_reg != '0) begin
                            live_next = live_reg - 1'b1;
                        end
                        if (tid_reg == cur_reg) begin
                            rounds_next = '0;
                            state_next  = S_SCH0;
                        end
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_PF2: begin
                if (head_reg == NIL) begin
                    tail_next = LW'(tid_reg);
                end else begin
                    pv_we = 1'b1;
                    pv_wa = IW'(head_reg);
                    pv_wd = LW'(tid_reg);
                end
                head_next  = LW'(tid_reg);
                state_next = S_DONE;
            end
            S_SCH0: begin
                rd_addr    = cur_reg;
                state_next = S_SCH1;
            end
            S_SCH1: begin
                state_next = S_PICK;
                if (rounds_reg != '0 && alive) begin
                    rounds_next   = rounds_reg - 1'b1;
                    status_next   = STS_OK;
                    switched_next = 1'b0;
                    state_next    = S_DONE;
                end else if (alive && st_rd_reg == TS_RUNNING && cur_reg != '0) begin
                    // preempted: drop a level and requeue at the tail
                    pr_we = 1'b1;
                    pr_wa = cur_reg;
                    pr_wd = (pr_rd_reg != 2'd0) ? pr_rd_reg - 2'd1 : 2'd0;
                    st_we = 1'b1;
                    st_wa = cur_reg;
                    st_wd = TS_READY;
                    unlink_en       = inlist_reg[cur_reg];
                    unlink_t        = cur_reg;
                    t_next          = cur_reg;
                    ret_create_next = 1'b0;
                    state_next      = S_APP1;
                end else if (alive && cur_reg == '0) begin
                    st_we = 1'b1;
                    st_wa = cur_reg;
                    st_wd = TS_READY;
                end
            end
            S_APP1: begin
                nx_we = 1'b1;
                nx_wa = t_reg;
                nx_wd = NIL;
                pv_we = 1'b1;
                pv_wa = t_reg;
                pv_wd = tail_reg;
                inlist_next[t_reg] = 1'b1;
                if (tail_reg == NIL) begin
                    head_next  = LW'(t_reg);
                    tail_next  = LW'(t_reg);
                    state_next = ret_create_reg ? S_CUR : S_PICK;
                end else begin
                    state_next = S_APP2;
                end
            end
            S_APP2: begin
                nx_we      = 1'b1;
                nx_wa      = IW'(tail_reg);
                nx_wd      = LW'(t_reg);
                tail_next  = LW'(t_reg);
                state_next = ret_create_reg ? S_CUR : S_PICK;
            end
            S_PICK: begin
                rd_addr = pick;
                t_next  = pick;
                if (!valid_reg[pick]) begin
                    cur_next      = '0;
                    rounds_next   = '0;
                    status_next   = STS_NOIDLE;
                    switched_next = 1'b0;
                    state_next    = S_DONE;
                end else begin
                    state_next = S_PICK2;
                end
            end
            S_PICK2: begin
                rounds_next   = 3'(pr_rd_reg) + 3'd1;
                st_we         = 1'b1;
                st_wa         = t_reg;
                st_wd         = TS_RUNNING;
                cur_next      = t_reg;
                status_next   = STS_OK;
                switched_next = 1'b1;
                state_next    = S_DONE;
            end
            S_CSCAN: begin
                if (!valid_reg[scan_reg]) begin
                    valid_next[scan_reg]  = 1'b1;
                    inlist_next[scan_reg] = 1'b0;
                    pr_we = 1'b1;
                    pr_wa = scan_reg;
                    pr_wd = prio_reg;
                    st_we = 1'b1;
                    st_wa = scan_reg;
                    st_wd = TS_READY;
                    live_next       = live_reg + 1'b1;
                    value_next      = 7'(scan_reg);
                    status_next     = STS_OK;
                    t_next          = scan_reg;
                    slot_next       = scan_reg;
                    scan_next       = wrap_inc(scan_reg);
                    ret_create_next = 1'b1;
                    // the idle task is never queued
                    state_next      = (scan_reg != '0) ? S_APP1 : S_CUR;
                end else begin
                    scan_next = wrap_inc(scan_reg);
                end
            end
            S_CUR: begin
                if (!valid_reg[scan_reg]) begin
                    cursor_next = scan_reg;
                    state_next  = S_DONE;
                end else if (scan_reg == slot_reg) begin
                    cursor_next = wrap_inc(slot_reg);
                    state_next  = S_DONE;
                end else begin
                    scan_next = wrap_inc(scan_reg);
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next      = 1'b1;
                    out_next.status   = status_reg;
                    out_next.running  = 7'(cur_reg);
                    out_next.switched = switched_reg;
                    out_next.value    = value_reg;
                    out_next.quantum  = rounds_reg;
                    state_next        = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // unlink from the ready list using the links read for unlink_t
        if (unlink_en) begin
            if (pv_rd_reg == NIL) begin
                head_next = nx_rd_reg;
            end else begin
                nx_we = 1'b1;
                nx_wa = IW'(pv_rd_reg);
                nx_wd = nx_rd_reg;
            end
            if (nx_rd_reg == NIL) begin
                tail_next = pv_rd_reg;
            end else begin
                pv_we = 1'b1;
                pv_wa = IW'(nx_rd_reg);
                pv_wd = pv_rd_reg;
            end
            inlist_next[unlink_t] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (st_we) st_mem[st_wa] <= st_wd;
        if (pr_we) pr_mem[pr_wa] <= pr_wd;
        if (nx_we) nx_mem[nx_wa] <= nx_wd;
        if (pv_we) pv_mem[pv_wa] <= pv_wd;
        st_rd_reg <= st_mem[rd_addr];
        pr_rd_reg <= pr_mem[rd_addr];
        nx_rd_reg <= nx_mem[rd_addr];
        pv_rd_reg <= pv_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            inlist_reg  <= '0;
            head_reg    <= NIL;
            tail_reg    <= NIL;
            cur_reg     <= '0;
            cursor_reg  <= '0;
            live_reg    <= '0;
            rounds_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            inlist_reg  <= inlist_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            cur_reg     <= cur_next;
            cursor_reg  <= cursor_next;
            live_reg    <= live_next;
            rounds_reg  <= rounds_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg        <= out_next;
        op_reg         <= op_next;
        tid_reg        <= tid_next;
        t_reg          <= t_next;
        slot_reg       <= slot_next;
        scan_reg       <= scan_next;
        prio_reg       <= prio_next;
        status_reg     <= status_next;
        value_reg      <= value_next;
        switched_reg   <= switched_next;
        ret_create_reg <= ret_create_next;
    end

    a_list_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (head_reg == NIL) == (tail_reg == NIL))
        else $error("ready list head and tail disagree on empty");

    a_live_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        live_reg <= LVW'(MAX_TASKS))
        else $error("live task count above table size");

    a_pick_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PICK2) |=> valid_reg[cur_reg])
        else $error("picked task is not a valid slot");

    a_noidle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && status_reg == STS_NOIDLE) |-> (cur_reg == '0 && rounds_reg == '0))
        else $error("no-idle result with a running task or quantum");

endmodule
`default_nettype wire

/* sv/priority_quantum_task_scheduler_core.sv */
`default_nettype none
// task scheduler core: one result word for every event word
// s_ channel: s_tuser carries the event code (tick, create, set priority,
//   block, make ready, kill); s_tdata carries task id and priority
// m_ channel: status, running task, switched flag, result value, quantum
// the front classifies events and pushes them into a 4-entry queue, so
// s_tready stays high while the back is busy until the queue fills
// back side: rejects and set priority go from idle to done; block, make
//   ready and kill pass the exec step (make ready may add a head link step),
//   and ticks and block or kill of the running task run the schedule steps
// create scans the valid bits one slot per cycle, twice (free slot search,
//   then next free cursor)
// the back takes one event at a time through its sequencer; each task table
//   memory has one read port and one write port
// reset (aresetn low, synchronous) empties the table, the ready list and
//   the queue; no clearing pass is needed
// when m_tready is low the result stays in the output register; the back
//   finishes the next event and holds in its final step until the register
//   frees up, and the queue keeps taking events meanwhile
module priority_quantum_task_scheduler_core import pqts_pkg::*; #(
    parameter int MAX_TASKS  = MAX_TASKS_DEF,
    parameter int NUM_LEVELS = NUM_LEVELS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // task_id[6:0], priority_req[8:7], zero
    input  wire logic [2:0]  s_tuser,   // mode[2:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // status[1:0], running_task[8:2], switched[9],
                                        // result_value[16:10], quantum_left[19:17], zero
);

    entry_t  push_entry, head_entry;
    logic    push, full, pop, not_empty;
    result_t result;

    pqts_front #(
        .MAX_TASKS  (MAX_TASKS),
        .NUM_LEVELS (NUM_LEVELS)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (full),
        .q_push   (push),
        .q_entry  (push_entry)
    );

    pqts_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_entry),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head_entry)
    );

    pqts_back #(
        .MAX_TASKS (MAX_TASKS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (not_empty),
        .q_entry  (head_entry),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (result)
    );

    assign m_tdata = {4'b0, result};

endmodule
`default_nettype wire
